// ===== src/pfc_pkg.sv =====
`default_nettype none

package pfc_pkg;

  // Key square geometry
  localparam int unsigned SQUARE_SIDE = 5;
  localparam int unsigned CELLS       = SQUARE_SIDE * SQUARE_SIDE;
  localparam int unsigned CODE_W      = 5;
  localparam int unsigned RC_W        = $clog2(SQUARE_SIDE);
  localparam int unsigned POS_W       = $clog2(CELLS);

  // Letter and byte constants
  localparam logic [7:0] ASCII_A_8   = 8'd65;
  localparam logic [7:0] ASCII_Z_8   = 8'd90;
  localparam logic [7:0] LOWER_A_8   = 8'd97;
  localparam logic [7:0] LOWER_Z_8   = 8'd122;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [6:0] ASCII_A     = 7'd65;
  localparam logic [6:0] ASCII_Z     = 7'd90;
  localparam logic [6:0] LAST_CODE   = 7'd25;

  // Default depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration port
  localparam int unsigned CFG_DATA_W = 50;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECRYPT_MODE  = 3'd0,
    REG_SQUARE_UPPER  = 3'd1,
    REG_SQUARE_MIDDLE = 3'd2,
    REG_SQUARE_BOTTOM = 3'd3,
    REG_DOUBLE_FILL   = 3'd4,
    REG_EXTRA_FILL    = 3'd5,
    REG_OMIT_LETTER   = 3'd6,
    REG_REPLACE_LETTER = 3'd7
  } cfg_reg_e;

  // Reset values of the letter registers
  localparam logic [6:0] FILL_RESET    = 7'd88;
  localparam logic [6:0] OMIT_RESET    = 7'd74;
  localparam logic [6:0] REPLACE_RESET = 7'd73;

  // Square: position p holds a five-bit letter code
  typedef logic [CELLS-1:0][CODE_W-1:0] square_t;

  // Letter handling settings seen by the front
  typedef struct packed {
    logic       decrypt;
    logic [6:0] double_fill;
    logic [6:0] extra_fill;
    logic [6:0] omit;
    logic [6:0] replace;
  } text_cfg_t;

  typedef struct packed {
    logic [6:0] a;
    logic [6:0] b;
  } pair_t;

  // One queued job: the results caused by one input byte
  typedef struct packed {
    pair_t first;
    pair_t second;
    logic  two;
    logic  bare;
    logic  eom;
    logic  decrypt;
  } job_t;

  typedef struct packed {
    logic            found;
    logic [RC_W-1:0] row;
    logic [RC_W-1:0] col;
  } loc_t;

  // Fill letter for a partner: swap the omitted letter, bump a clash when enciphering
  function automatic logic [6:0] fill_for(logic [6:0] fill, logic [6:0] omit,
                                          logic [6:0] replace, logic decrypt,
                                          logic [6:0] partner);
    logic [6:0] f;
    f = fill;
    if (f == omit) begin
      f = replace;
    end
    if (!decrypt && (f == partner)) begin
      f = (f == ASCII_Z) ? ASCII_A : f + 7'd1;
    end
    return f;
  endfunction

  // Lowest square position holding the letter
  function automatic loc_t find_cell(square_t sq, logic [6:0] ascii);
    loc_t            loc;
    logic [CODE_W-1:0] code;
    loc  = '0;
    code = CODE_W'(ascii - ASCII_A);
    if ((ascii >= ASCII_A) && (ascii <= ASCII_Z)) begin
      for (int r = SQUARE_SIDE - 1; r >= 0; r--) begin
        for (int c = SQUARE_SIDE - 1; c >= 0; c--) begin
          if (sq[r * SQUARE_SIDE + c] == code) begin
            loc.found = 1'b1;
            loc.row   = RC_W'(r);
            loc.col   = RC_W'(c);
          end
        end
      end
    end
    return loc;
  endfunction

  // Step along a row or column with wrap-around
  function automatic logic [RC_W-1:0] wrap_step(logic [RC_W-1:0] idx, logic decrypt);
    logic [RC_W:0] sum;
    sum = {1'b0, idx} + (decrypt ? (RC_W+1)'(SQUARE_SIDE - 1) : (RC_W+1)'(1));
    if (sum >= (RC_W+1)'(SQUARE_SIDE)) begin
      sum = sum - (RC_W+1)'(SQUARE_SIDE);
    end
    return sum[RC_W-1:0];
  endfunction

  // Letter at a square cell; codes beyond Z read as Z
  function automatic logic [6:0] cell_ascii(square_t sq, logic [RC_W-1:0] row,
                                            logic [RC_W-1:0] col);
    logic [POS_W-1:0] pos;
    logic [6:0]       code;
    pos  = POS_W'(row * POS_W'(SQUARE_SIDE)) + POS_W'(col);
    code = {2'b00, sq[pos]};
    return (code > LAST_CODE) ? ASCII_Z : ASCII_A + code;
  endfunction

endpackage

`default_nettype wire

// ===== src/pfc_front.sv =====
`default_nettype none

module pfc_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pfc_pkg::text_cfg_t cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        in_char_i,
  input  wire logic              in_eom_i,
  output logic                   job_valid_o,
  input  wire logic              job_ready_i,
  output pfc_pkg::job_t          job_o
);
  import pfc_pkg::*;

  logic [CODE_W-1:0] held_q, held_d;
  logic              holding_q, holding_d;

  logic [7:0]        up_char;
  logic [7:0]        sym;
  logic              is_letter;
  logic [6:0]        held_ascii;
  logic              pair_op;
  logic              doubled;
  logic [CODE_W-1:0] held_mid;
  logic              holding_mid;
  logic              pad_op;
  pair_t             pad_pair;
  logic              accept;

  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Fold case and swap the omitted letter
  always_comb begin
    up_char = ((in_char_i >= LOWER_A_8) && (in_char_i <= LOWER_Z_8)) ?
              in_char_i - CASE_OFFSET : in_char_i;
    sym       = (up_char == {1'b0, cfg_i.omit}) ? {1'b0, cfg_i.replace} : up_char;
    is_letter = (sym >= ASCII_A_8) && (sym <= ASCII_Z_8);
  end

  // Classify the byte against the held letter
  always_comb begin
    held_ascii  = {2'b00, held_q} + ASCII_A;
    pair_op     = is_letter && holding_q;
    doubled     = pair_op && !cfg_i.decrypt && (held_ascii == sym[6:0]);
    held_mid    = held_q;
    holding_mid = holding_q;
    if (is_letter && !holding_q) begin
      held_mid    = CODE_W'(sym - ASCII_A_8);
      holding_mid = 1'b1;
    end else if (pair_op && !doubled) begin
      holding_mid = 1'b0;
    end
    pad_op     = in_eom_i && holding_mid;
    pad_pair.a = {2'b00, held_mid} + ASCII_A;
    pad_pair.b = fill_for(cfg_i.extra_fill, cfg_i.omit, cfg_i.replace, cfg_i.decrypt,
                          {2'b00, held_mid} + ASCII_A);
  end

  // Build the job for the queue
  always_comb begin
    job_o.second = pad_pair;
    if (pair_op) begin
      job_o.first.a = held_ascii;
      job_o.first.b = doubled ?
                      fill_for(cfg_i.double_fill, cfg_i.omit, cfg_i.replace,
                               cfg_i.decrypt, held_ascii) :
                      sym[6:0];
    end else begin
      job_o.first = pad_pair;
    end
    job_o.two     = pair_op && pad_op;
    job_o.bare    = in_eom_i && !pair_op && !pad_op;
    job_o.eom     = in_eom_i;
    job_o.decrypt = cfg_i.decrypt;
    job_valid_o   = accept && (pair_op || in_eom_i);
  end

  // Advance the held letter; end of message always clears it
  always_comb begin
    held_d    = held_q;
    holding_d = holding_q;
    if (accept) begin
      if (in_eom_i) begin
        held_d    = '0;
        holding_d = 1'b0;
      end else begin
        held_d    = held_mid;
        holding_d = holding_mid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      holding_q <= 1'b0;
    end else begin
      held_q    <= held_d;
      holding_q <= holding_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/pfc_fifo.sv =====
`default_nettype none

module pfc_fifo #(
  parameter int unsigned Depth = pfc_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  input  wire pfc_pkg::job_t wr_data_i,
  output logic               rd_valid_o,
  input  wire logic          rd_ready_i,
  output pfc_pkg::job_t      rd_data_o
);
  import pfc_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] ptr);
    return (ptr == PtrW'(Depth - 1)) ? '0 : ptr + PtrW'(1);
  endfunction

  assign wr_ready_o = (count_q != CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = slot_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Move the pointers and the fill count
  always_comb begin
    wr_ptr_d = push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the job
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/pfc_back.sv =====
`default_nettype none

module pfc_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire pfc_pkg::square_t square_i,
  input  wire logic             job_valid_i,
  output logic                  job_ready_o,
  input  wire pfc_pkg::job_t    job_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [6:0]            out_first_o,
  output logic [6:0]            out_second_o,
  output logic                  out_pair_valid_o,
  output logic                  out_error_o,
  output logic                  out_last_o,
  output logic                  out_msg_end_o
);
  import pfc_pkg::*;

  // Lookup stage
  logic  idx_q, idx_d;
  logic  s1_valid_q, s1_valid_d;
  loc_t  s1_loc_a_q, s1_loc_b_q;
  logic  s1_decrypt_q, s1_bare_q, s1_last_q, s1_msg_end_q;

  // Output stage
  logic       out_valid_q, out_valid_d;
  logic [6:0] out_first_q, out_first_d;
  logic [6:0] out_second_q, out_second_d;
  logic       out_pair_valid_q, out_pair_valid_d;
  logic       out_error_q, out_error_d;
  logic       out_last_q, out_msg_end_q;

  pair_t cur_pair;
  logic  cur_last;
  logic  s1_load;
  logic  s2_load;
  loc_t  loc_a, loc_b;

  // Pick the pair of the job now at the head
  always_comb begin
    cur_pair = idx_q ? job_i.second : job_i.first;
    cur_last = job_i.two ? idx_q : 1'b1;
    loc_a    = find_cell(square_i, cur_pair.a);
    loc_b    = find_cell(square_i, cur_pair.b);
  end

  // Stage handshakes: advance when the next stage is free or draining
  always_comb begin
    s2_load     = s1_valid_q && (!out_valid_q || out_ready_i);
    s1_load     = job_valid_i && (!s1_valid_q || s2_load);
    job_ready_o = s1_load && (!job_i.two || idx_q);
    idx_d       = s1_load ? (job_i.two && !idx_q) : idx_q;
    s1_valid_d  = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_q);
    out_valid_d = s2_load ? 1'b1 : ((out_valid_q && out_ready_i) ? 1'b0 : out_valid_q);
  end

  // Form the output digram from the located cells, or mark a bare job or a failed lookup
  always_comb begin
    out_pair_valid_d = 1'b1;
    out_error_d      = 1'b0;
    if (s1_bare_q) begin
      out_first_d      = '0;
      out_second_d     = '0;
      out_pair_valid_d = 1'b0;
    end else if (!s1_loc_a_q.found || !s1_loc_b_q.found) begin
      out_first_d  = ASCII_A;
      out_second_d = ASCII_A;
      out_error_d  = 1'b1;
    end else if (s1_loc_a_q.row == s1_loc_b_q.row) begin
      out_first_d  = cell_ascii(square_i, s1_loc_a_q.row,
                                wrap_step(s1_loc_a_q.col, s1_decrypt_q));
      out_second_d = cell_ascii(square_i, s1_loc_b_q.row,
                                wrap_step(s1_loc_b_q.col, s1_decrypt_q));
    end else if (s1_loc_a_q.col == s1_loc_b_q.col) begin
      out_first_d  = cell_ascii(square_i, wrap_step(s1_loc_a_q.row, s1_decrypt_q),
                                s1_loc_a_q.col);
      out_second_d = cell_ascii(square_i, wrap_step(s1_loc_b_q.row, s1_decrypt_q),
                                s1_loc_b_q.col);
    end else begin
      out_first_d  = cell_ascii(square_i, s1_loc_a_q.row, s1_loc_b_q.col);
      out_second_d = cell_ascii(square_i, s1_loc_b_q.row, s1_loc_a_q.col);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold stage payloads until they move on
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_loc_a_q   <= loc_a;
      s1_loc_b_q   <= loc_b;
      s1_decrypt_q <= job_i.decrypt;
      s1_bare_q    <= job_i.bare;
      s1_last_q    <= cur_last;
      s1_msg_end_q <= job_i.eom && cur_last;
    end
    if (s2_load) begin
      out_first_q      <= out_first_d;
      out_second_q     <= out_second_d;
      out_pair_valid_q <= out_pair_valid_d;
      out_error_q      <= out_error_d;
      out_last_q       <= s1_last_q;
      out_msg_end_q    <= s1_msg_end_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_first_o      = out_first_q;
  assign out_second_o     = out_second_q;
  assign out_pair_valid_o = out_pair_valid_q;
  assign out_error_o      = out_error_q;
  assign out_last_o       = out_last_q;
  assign out_msg_end_o    = out_msg_end_q;

endmodule

`default_nettype wire

// ===== src/playfair_digram_cipher.sv =====
// Channel   Direction  tdata (low bit first)                    tuser / tlast
// s_axis    in         [7:0] char_in                            tlast: end_of_message
// m_axis    out        [6:0] first_letter, [13:7] second_letter tuser: pair_valid,
//                                                                 lookup_error, message_end;
//                                                                 tlast: last_in_run
// cfg       in         write enable, register index, 50-bit data
//
// One byte is taken every cycle while the job queue has room. A byte that makes two
// digrams holds the output side for both, one digram per cycle while the output is
// ready; the queue absorbs the difference. A byte's first digram is presented through
// three registers: queue slot, cell lookup stage and output register. Reset clears
// the held letter, the queue, the stage valids and the configuration registers to
// their defaults. A stalled output stalls the back part first and the input once the
// queue is full.
`default_nettype none

module playfair_digram_cipher #(
  parameter int unsigned QueueDepth = pfc_pkg::QUEUE_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [pfc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,  // [7:0] char_in
  input  wire logic                           s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [15:0]                         m_axis_tdata,  // first_letter, second_letter
  output logic [2:0]                          m_axis_tuser,  // pair_valid, lookup_error,
                                                             // message_end
  output logic                                m_axis_tlast
);
  import pfc_pkg::*;

  logic                     decrypt_q;
  logic [CFG_DATA_W-1:0]    sq_upper_q;
  logic [CFG_DATA_W-1:0]    sq_middle_q;
  logic [CELLS*CODE_W-2*CFG_DATA_W-1:0] sq_bottom_q;
  logic [6:0]               double_fill_q;
  logic [6:0]               extra_fill_q;
  logic [6:0]               omit_q;
  logic [6:0]               replace_q;

  text_cfg_t text_cfg;
  square_t   square;
  logic      job_valid;
  logic      job_ready;
  job_t      job;
  logic      head_valid;
  logic      head_ready;
  job_t      head;
  logic [6:0] first_letter;
  logic [6:0] second_letter;
  logic      pair_valid;
  logic      lookup_error;
  logic      message_end;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q     <= 1'b0;
      sq_upper_q    <= '0;
      sq_middle_q   <= '0;
      sq_bottom_q   <= '0;
      double_fill_q <= FILL_RESET;
      extra_fill_q  <= FILL_RESET;
      omit_q        <= OMIT_RESET;
      replace_q     <= REPLACE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_DECRYPT_MODE:   decrypt_q     <= cfg_wdata_i[0];
        REG_SQUARE_UPPER:   sq_upper_q    <= cfg_wdata_i;
        REG_SQUARE_MIDDLE:  sq_middle_q   <= cfg_wdata_i;
        REG_SQUARE_BOTTOM:  sq_bottom_q   <= cfg_wdata_i[$bits(sq_bottom_q)-1:0];
        REG_DOUBLE_FILL:    double_fill_q <= cfg_wdata_i[6:0];
        REG_EXTRA_FILL:     extra_fill_q  <= cfg_wdata_i[6:0];
        REG_OMIT_LETTER:    omit_q        <= cfg_wdata_i[6:0];
        REG_REPLACE_LETTER: replace_q     <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  assign square               = square_t'({sq_bottom_q, sq_middle_q, sq_upper_q});
  assign text_cfg.decrypt     = decrypt_q;
  assign text_cfg.double_fill = double_fill_q;
  assign text_cfg.extra_fill  = extra_fill_q;
  assign text_cfg.omit        = omit_q;
  assign text_cfg.replace     = replace_q;

  pfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (text_cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_char_i   (s_axis_tdata),
    .in_eom_i    (s_axis_tlast),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  pfc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (job_valid),
    .wr_ready_o (job_ready),
    .wr_data_i  (job),
    .rd_valid_o (head_valid),
    .rd_ready_i (head_ready),
    .rd_data_o  (head)
  );

  pfc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .square_i         (square),
    .job_valid_i      (head_valid),
    .job_ready_o      (head_ready),
    .job_i            (head),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_first_o      (first_letter),
    .out_second_o     (second_letter),
    .out_pair_valid_o (pair_valid),
    .out_error_o      (lookup_error),
    .out_last_o       (m_axis_tlast),
    .out_msg_end_o    (message_end)
  );

  assign m_axis_tdata = {2'b00, second_letter, first_letter};
  assign m_axis_tuser = {message_end, lookup_error, pair_valid};

endmodule

`default_nettype wire
